>>> sv/fhd_pkg.sv
// ----------------------------------------------------------------------------
// fhd_pkg
// Shared types and constants for the frame header deframer: parse phases,
// result kinds, status codes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package fhd_pkg;

  localparam int unsigned HDR_LEN   = 16;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned HDR_BITS  = HDR_LEN * 8;
  localparam int unsigned TOTAL_W   = 33;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_VERSION = 2'd1;
  localparam logic [1:0] CFG_MAXLEN  = 2'd2;
  localparam logic [1:0] CFG_TYPES   = 2'd3;

  localparam logic [CNT_W-1:0] LAST_HDR_IDX = CNT_W'(HDR_LEN - 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_SHORT   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_COMPLETE    = 3'd0,
    ST_NEED_MORE   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_UNKNOWN     = 3'd4,
    ST_TOO_LARGE   = 3'd5,
    ST_HEADER_OK   = 3'd6
  } status_t;

  // One result as queued between front and back
  typedef struct packed {
    kind_t        kind;
    status_t      status;
    logic [7:0]   data;
    logic         last;
    logic         hdr;        // header fields are valid for this result
    logic         zero_total; // error verdict: needed total reads zero
    logic [15:0]  msg_type;
    logic [31:0]  req_id;
    logic [31:0]  pay_len;
  } entry_t;

  // Push request from front to back: up to two results per beat
  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

endpackage

>>> sv/fhd_front.sv
// ----------------------------------------------------------------------------
// fhd_front
// Accepts stream bytes, collects the header, checks it against the
// configuration and classifies each byte into zero, one or two results.
// ----------------------------------------------------------------------------
module fhd_front
  import fhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  byte_value,
  input  logic        buffer_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output push_t       push,
  output entry_t      entry0,
  output entry_t      entry1
);

  logic [31:0] magic_r;
  logic [15:0] version_r;
  logic [31:0] max_len_r;
  logic [63:0] type_mask_r;

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [31:0]         rem_r, rem_nxt;
  logic [HDR_BITS-9:0] hdr_r, hdr_nxt;
  logic [15:0]         type_r, type_nxt;
  logic [31:0]         rid_r, rid_nxt;
  logic [31:0]         len_r, len_nxt;

  logic [HDR_BITS-1:0] full_hdr;
  logic [31:0]         f_magic;
  logic [15:0]         f_version;
  logic [15:0]         f_type;
  logic [31:0]         f_rid;
  logic [31:0]         f_len;
  status_t             verdict;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r     <= '0;
      version_r   <= 16'd1;
      max_len_r   <= 32'd65536;
      type_mask_r <= 64'h3F_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC:   magic_r     <= cfg_wdata[31:0];
        CFG_VERSION: version_r   <= cfg_wdata[15:0];
        CFG_MAXLEN:  max_len_r   <= cfg_wdata[31:0];
        CFG_TYPES:   type_mask_r <= cfg_wdata;
        default:     magic_r     <= magic_r;
      endcase
    end
  end

  // Split the header as it stands with the current byte appended
  assign full_hdr  = {hdr_r, byte_value};
  assign f_magic   = full_hdr[127:96];
  assign f_version = full_hdr[95:80];
  assign f_type    = full_hdr[79:64];
  assign f_rid     = full_hdr[63:32];
  assign f_len     = full_hdr[31:0];

  // Check in order: magic, version, known type, payload limit
  always_comb begin
    priority if (f_magic != magic_r)                 verdict = ST_BAD_MAGIC;
    else if (f_version != version_r)                 verdict = ST_BAD_VERSION;
    else if ((f_type[15:6] != '0) || !type_mask_r[f_type[5:0]])
                                                     verdict = ST_UNKNOWN;
    else if (f_len > max_len_r)                      verdict = ST_TOO_LARGE;
    else if (f_len == '0)                            verdict = ST_COMPLETE;
    else                                             verdict = ST_HEADER_OK;
  end

  // Classify the accepted beat
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    hdr_nxt   = hdr_r;
    type_nxt  = type_r;
    rid_nxt   = rid_r;
    len_nxt   = len_r;
    push      = '0;

    entry0            = '0;
    entry0.msg_type   = type_r;
    entry0.req_id     = rid_r;
    entry0.pay_len    = len_r;
    entry0.kind       = KIND_SHORT;
    entry0.status     = ST_NEED_MORE;
    entry1            = '0;
    entry1.msg_type   = type_r;
    entry1.req_id     = rid_r;
    entry1.pay_len    = len_r;
    entry1.kind       = KIND_SHORT;
    entry1.status     = ST_NEED_MORE;
    entry1.hdr        = 1'b1;

    if (accept) begin
      unique case (phase_r)
        PH_DROP: begin
          // drop bytes up to the end of the buffer
          if (buffer_end) begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt      = rem_r - 32'd1;
          push.v0      = 1'b1;
          entry0.kind  = KIND_PAYLOAD;
          entry0.data  = byte_value;
          entry0.hdr   = 1'b1;
          if (rem_r == 32'd1) begin
            entry0.status = ST_COMPLETE;
            entry0.last   = 1'b1;
            phase_nxt     = PH_HEADER;
            cnt_nxt       = '0;
          end else begin
            entry0.status = ST_NEED_MORE;
            push.v1       = buffer_end;
          end
        end
        default: begin
          // header collection, also taken for the unused phase code
          phase_nxt = PH_HEADER;
          hdr_nxt   = full_hdr[HDR_BITS-9:0];
          if (cnt_r != LAST_HDR_IDX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            push.v0 = buffer_end;
          end else begin
            cnt_nxt         = '0;
            type_nxt        = f_type;
            rid_nxt         = f_rid;
            len_nxt         = f_len;
            push.v0         = 1'b1;
            entry0.kind     = KIND_VERDICT;
            entry0.status   = verdict;
            entry0.hdr      = 1'b1;
            entry0.msg_type = f_type;
            entry0.req_id   = f_rid;
            entry0.pay_len  = f_len;
            entry1.msg_type = f_type;
            entry1.req_id   = f_rid;
            entry1.pay_len  = f_len;
            unique case (verdict)
              ST_HEADER_OK: begin
                rem_nxt   = f_len;
                phase_nxt = PH_PAYLOAD;
                push.v1   = buffer_end;
              end
              ST_COMPLETE: begin
                entry0.last = 1'b1;
              end
              default: begin
                entry0.last       = 1'b1;
                entry0.zero_total = 1'b1;
                phase_nxt         = buffer_end ? PH_HEADER : PH_DROP;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Header bytes and latched header fields
  always_ff @(posedge clk) begin
    hdr_r  <= hdr_nxt;
    type_r <= type_nxt;
    rid_r  <= rid_nxt;
    len_r  <= len_nxt;
  end

endmodule

>>> sv/fhd_back.sv
// ----------------------------------------------------------------------------
// fhd_back
// Result queue between the byte classifier and the output channel; formats
// the head entry into the result fields and hands it out one beat at a time.
// ----------------------------------------------------------------------------
module fhd_back
  import fhd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  push_t                push,
  input  entry_t               entry0,
  input  entry_t               entry1,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_item_kind,
  output logic [2:0]           out_status,
  output logic [15:0]          out_message_type,
  output logic [31:0]          out_req_ident,
  output logic [31:0]          out_payload_length,
  output logic [TOTAL_W-1:0]   out_needed_total,
  output logic [7:0]           out_data_byte,
  output logic                 out_frame_last
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   wr_p1;
  logic               pop;
  entry_t             head;

  assign wr_p1     = wr_r + PTR_W'(1);
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // take a byte only while two slots are free
  assign room      = (cnt_r <= (PTR_W+1)'(DEPTH - 2));

  // Advance pointers and fill level
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push.v0 && push.v1) begin
      wr_nxt  = wr_r + PTR_W'(2);
      cnt_nxt = cnt_nxt + (PTR_W+1)'(2);
    end else if (push.v0) begin
      wr_nxt  = wr_p1;
      cnt_nxt = cnt_nxt + (PTR_W+1)'(1);
    end
    if (pop) begin
      rd_nxt  = rd_r + PTR_W'(1);
      cnt_nxt = cnt_nxt - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store queued results
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_r] <= entry0;
    end
    if (push.v0 && push.v1) begin
      mem[wr_p1] <= entry1;
    end
  end

  // Format the head entry
  assign head               = mem[rd_r];
  assign out_item_kind      = head.kind;
  assign out_status         = head.status;
  assign out_data_byte      = head.data;
  assign out_frame_last     = head.last;
  assign out_message_type   = head.hdr ? head.msg_type : '0;
  assign out_req_ident      = head.hdr ? head.req_id : '0;
  assign out_payload_length = head.hdr ? head.pay_len : '0;

  always_comb begin
    priority if (head.zero_total) out_needed_total = '0;
    else if (head.hdr)            out_needed_total = TOTAL_W'(head.pay_len)
                                                     + TOTAL_W'(HDR_LEN);
    else                          out_needed_total = TOTAL_W'(HDR_LEN);
  end

endmodule

>>> sv/frame_header_deframer.sv
// ----------------------------------------------------------------------------
// frame_header_deframer
// Length-prefixed frame deframer: collects a 16-byte header from a byte
// stream, checks it, reports a verdict and passes payload bytes through.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the queue has room. A byte yields
// zero, one or two results (a payload or header byte that closes a buffer
// early adds a need-more result); results go into a four-entry queue and
// leave one per cycle while out_ready is high, so the sustained rate is
// one byte per cycle while each byte gives at most one result, and the
// input ready drops whenever more than two results are queued. Header
// checks and the payload countdown sit in the front classifier; the
// single output port of the queue sets the result rate.
module frame_header_deframer
  import fhd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte_value,
  input  logic                in_buffer_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_item_kind,
  output logic [2:0]          out_status,
  output logic [15:0]         out_message_type,
  output logic [31:0]         out_req_ident,
  output logic [31:0]         out_payload_length,
  output logic [TOTAL_W-1:0]  out_needed_total,
  output logic [7:0]          out_data_byte,
  output logic                out_frame_last,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);

  push_t  push;
  entry_t entry0;
  entry_t entry1;
  logic   room;
  logic   accept;

  assign in_ready = room;
  assign accept   = in_valid && room;

  fhd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_byte_value),
    .buffer_end (in_buffer_end),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .entry0     (entry0),
    .entry1     (entry1)
  );

  fhd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .entry0             (entry0),
    .entry1             (entry1),
    .room               (room),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_item_kind      (out_item_kind),
    .out_status         (out_status),
    .out_message_type   (out_message_type),
    .out_req_ident      (out_req_ident),
    .out_payload_length (out_payload_length),
    .out_needed_total   (out_needed_total),
    .out_data_byte      (out_data_byte),
    .out_frame_last     (out_frame_last)
  );

endmodule
